/* rtl/stc_pkg.sv */
// Shared types, character constants and keyword texts of the script type classifier.
package stc_pkg;

  // Default limit on the trimmed attribute length.
  localparam int unsigned STC_MAX_LEN = 128;

  // Widest keyword held in a chain of match cells.
  localparam int unsigned STC_TEXT_CHARS = 16;

  // Keyword text, right-justified: character i of a text of length L sits at index L-1-i.
  typedef logic [STC_TEXT_CHARS-1:0][7:0] stc_text_t;

  localparam stc_text_t STC_TEXT_JAVASCRIPT = "javascript";
  localparam stc_text_t STC_TEXT_ECMASCRIPT = "ecmascript";
  localparam stc_text_t STC_TEXT_MODULE     = "module";
  localparam stc_text_t STC_TEXT_IMPORTMAP  = "importmap";
  localparam stc_text_t STC_TEXT_SPECRULES  = "speculationrules";

  localparam int unsigned STC_LEN_JAVASCRIPT = 10;
  localparam int unsigned STC_LEN_ECMASCRIPT = 10;
  localparam int unsigned STC_LEN_MODULE     = 6;
  localparam int unsigned STC_LEN_IMPORTMAP  = 9;
  localparam int unsigned STC_LEN_SPECRULES  = 16;

  // ASCII whitespace and case folding.
  localparam logic [7:0] STC_CHAR_TAB   = 8'h09;
  localparam logic [7:0] STC_CHAR_LF    = 8'h0A;
  localparam logic [7:0] STC_CHAR_FF    = 8'h0C;
  localparam logic [7:0] STC_CHAR_CR    = 8'h0D;
  localparam logic [7:0] STC_CHAR_SPACE = 8'h20;
  localparam logic [7:0] STC_CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] STC_CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] STC_CASE_OFFSET  = 8'd32;

  // Result codes.
  typedef enum logic [2:0] {
    STC_CLASS_CLASSIC    = 3'd0,
    STC_CLASS_MODULE     = 3'd1,
    STC_CLASS_IMPORTMAP  = 3'd2,
    STC_CLASS_SPECRULES  = 3'd3,
    STC_CLASS_NONE       = 3'd4
  } stc_class_e;

  // Control shared by every match cell for one accepted byte.
  typedef struct packed {
    logic en;       // a transaction is accepted this cycle
    logic adv;      // the byte is a non-whitespace character
    logic restart;  // inner whitespace came before this character
    logic start;    // a match may begin at this character
    logic flush;    // the attribute ends here
  } stc_cell_ctrl_t;

endpackage

/* rtl/stc_match_cell.sv */
// One match cell: holds whether the keyword prefix ending at this character has matched.
module stc_match_cell #(
  parameter logic [7:0] EXP = 8'h00
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  stc_pkg::stc_cell_ctrl_t ctrl_i,
  input  logic [7:0]            ch_i,
  input  logic                  prev_i,
  output logic                  match_q_o,
  output logic                  match_d_o
);
  import stc_pkg::*;

  logic match_q;
  logic match_d;

  // The prefix grows by this character when the neighbour matched and the character fits.
  always_comb begin
    match_d = match_q;
    if (ctrl_i.adv) begin
      match_d = prev_i && (ch_i == EXP);
    end
  end

  // State changes only on an accepted transaction and clears when the attribute ends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.en) begin
      match_q <= ctrl_i.flush ? 1'b0 : match_d;
    end
  end

  assign match_q_o = match_q;
  assign match_d_o = match_d;

endmodule

/* rtl/stc_keyword_chain.sv */
// A row of match cells that tracks one keyword, each cell feeding its right neighbour.
module stc_keyword_chain #(
  parameter int unsigned        LEN  = stc_pkg::STC_LEN_MODULE,
  parameter stc_pkg::stc_text_t TEXT = stc_pkg::STC_TEXT_MODULE
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  stc_pkg::stc_cell_ctrl_t ctrl_i,
  input  logic [7:0]              ch_i,
  output logic                    full_o
);
  import stc_pkg::*;

  logic [LEN-1:0] match_q;
  logic [LEN-1:0] match_d;
  logic [LEN-1:0] prev;

  // The first cell may start a match; later cells take their neighbour unless whitespace broke it.
  always_comb begin
    prev[0] = ctrl_i.start;
    for (int i = 1; i < LEN; i++) begin
      prev[i] = match_q[i-1] && !ctrl_i.restart;
    end
  end

  for (genvar g = 0; g < LEN; g++) begin : g_cell
    stc_match_cell #(
      .EXP(TEXT[LEN-1-g])
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl_i),
      .ch_i     (ch_i),
      .prev_i   (prev[g]),
      .match_q_o(match_q[g]),
      .match_d_o(match_d[g])
    );
  end

  // The whole keyword has matched, counting the character taken now.
  assign full_o = match_d[LEN-1];

endmodule

/* rtl/script_type_classifier.sv */
// Top level of the script type classifier: length tracking, keyword chains and result register.
// The class code is valid in the cycle after the transaction that ends the attribute.
// Throughput: one byte per cycle while in_ready_o is high; the keyword cells and the length adder each settle per byte.
// A held result does not block the input while the result register is being taken.
// Reset: rst_ni clears all match cells, counters and the result valid flag at once.
module script_type_classifier #(
  parameter int unsigned MAX_LEN = stc_pkg::STC_MAX_LEN
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_value_i,
  input  logic       is_last_i,
  input  logic       no_bytes_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] type_class_o
);
  import stc_pkg::*;

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam logic [LW-1:0] MaxLenW = LW'(MAX_LEN);

  logic           accept;
  logic           is_space;
  logic [7:0]     ch;
  logic           content_q, content_d;
  logic [LW-1:0]  span_q, span_d;
  logic [LW-1:0]  ws_q, ws_d;
  logic [LW:0]    span_sum;
  logic [LW:0]    ws_sum;
  logic           found_q, found_d;
  logic           js_full, es_full, mod_full, imp_full, spec_full;
  logic           out_valid_q;
  stc_class_e     class_q, class_d;
  stc_cell_ctrl_t sub_ctrl, kw_ctrl;

  // The result register frees the input whenever it is empty or being taken.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Whitespace test and folding of upper-case letters only.
  always_comb begin
    is_space = byte_value_i inside {STC_CHAR_TAB, STC_CHAR_LF, STC_CHAR_FF, STC_CHAR_CR,
                                    STC_CHAR_SPACE};
    ch = byte_value_i;
    if (byte_value_i inside {[STC_CHAR_UPPER_A:STC_CHAR_UPPER_Z]}) begin
      ch = byte_value_i + STC_CASE_OFFSET;
    end
  end

  // Cell control: substring chains may start anywhere, exact chains only at the first character.
  always_comb begin
    sub_ctrl.en      = accept;
    sub_ctrl.adv     = !no_bytes_i && !is_space;
    sub_ctrl.restart = content_q && (ws_q != '0);
    sub_ctrl.start   = 1'b1;
    sub_ctrl.flush   = is_last_i || no_bytes_i;
    kw_ctrl          = sub_ctrl;
    kw_ctrl.start    = !content_q;
  end

  stc_keyword_chain #(.LEN(STC_LEN_JAVASCRIPT), .TEXT(STC_TEXT_JAVASCRIPT)) u_js (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(sub_ctrl), .ch_i(ch), .full_o(js_full)
  );
  stc_keyword_chain #(.LEN(STC_LEN_ECMASCRIPT), .TEXT(STC_TEXT_ECMASCRIPT)) u_es (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(sub_ctrl), .ch_i(ch), .full_o(es_full)
  );
  stc_keyword_chain #(.LEN(STC_LEN_MODULE), .TEXT(STC_TEXT_MODULE)) u_mod (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(kw_ctrl), .ch_i(ch), .full_o(mod_full)
  );
  stc_keyword_chain #(.LEN(STC_LEN_IMPORTMAP), .TEXT(STC_TEXT_IMPORTMAP)) u_imp (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(kw_ctrl), .ch_i(ch), .full_o(imp_full)
  );
  stc_keyword_chain #(.LEN(STC_LEN_SPECRULES), .TEXT(STC_TEXT_SPECRULES)) u_spec (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(kw_ctrl), .ch_i(ch), .full_o(spec_full)
  );

  // Trimmed length and pending whitespace run, both saturating at the limit.
  always_comb begin
    span_sum  = {1'b0, span_q} + {1'b0, ws_q} + (LW+1)'(1);
    ws_sum    = {1'b0, ws_q} + (LW+1)'(1);
    content_d = content_q;
    span_d    = span_q;
    ws_d      = ws_q;
    found_d   = found_q || js_full || es_full;
    if (is_space) begin
      if (content_q) begin
        ws_d = (ws_sum > {1'b0, MaxLenW}) ? MaxLenW : ws_sum[LW-1:0];
      end
    end else begin
      content_d = 1'b1;
      span_d    = (span_sum > {1'b0, MaxLenW}) ? MaxLenW : span_sum[LW-1:0];
      ws_d      = '0;
    end
  end

  // Class of the attribute as it stands after this byte.
  always_comb begin
    if (no_bytes_i || !content_d) begin
      class_d = STC_CLASS_CLASSIC;
    end else if (span_d >= MaxLenW) begin
      class_d = STC_CLASS_NONE;
    end else if (found_d) begin
      class_d = STC_CLASS_CLASSIC;
    end else if (mod_full) begin
      class_d = STC_CLASS_MODULE;
    end else if (imp_full) begin
      class_d = STC_CLASS_IMPORTMAP;
    end else if (spec_full) begin
      class_d = STC_CLASS_SPECRULES;
    end else begin
      class_d = STC_CLASS_NONE;
    end
  end

  // Attribute state: updated per accepted transaction, cleared when the attribute ends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      content_q <= 1'b0;
      span_q    <= '0;
      ws_q      <= '0;
      found_q   <= 1'b0;
    end else if (accept) begin
      if (is_last_i || no_bytes_i) begin
        content_q <= 1'b0;
        span_q    <= '0;
        ws_q      <= '0;
        found_q   <= 1'b0;
      end else begin
        content_q <= content_d;
        span_q    <= span_d;
        ws_q      <= ws_d;
        found_q   <= found_d;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && (is_last_i || no_bytes_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (is_last_i || no_bytes_i)) begin
      class_q <= class_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign type_class_o = class_q;

`ifndef NO_ASSERTIONS
  // An absent attribute gives classic in the next cycle.
  a_no_bytes_classic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && no_bytes_i |=> out_valid_o && (type_class_o == STC_CLASS_CLASSIC))
    else $error("absent attribute did not give classic");

  // The byte that ends an attribute always produces a result.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_last_i |=> out_valid_o)
    else $error("last byte gave no result");

  // Attribute state is clear after the attribute ends.
  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (is_last_i || no_bytes_i) |=> !content_q && (span_q == '0) && !found_q)
    else $error("state not cleared after attribute end");

  // A pending result never carries a code outside the defined classes.
  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (type_class_o <= STC_CLASS_NONE))
    else $error("result code out of range");
`endif

endmodule

/* dv/tb_script_type_classifier.sv */
// Self-checking testbench of the script type classifier: attribute byte streams and a class predictor.
module tb_script_type_classifier;
  import stc_pkg::*;

  localparam int unsigned ATTR_MAX_LEN = STC_MAX_LEN;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_ready_o;
  logic [7:0] byte_value_i = 8'h00;
  logic       is_last_i    = 1'b0;
  logic       no_bytes_i   = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i  = 1'b0;
  logic [2:0] type_class_o;

  // Keyword texts and the byte sets that random values are drawn from.
  string exact_words[3]  = '{"module", "importmap", "speculationrules"};
  string script_words[2] = '{"javascript", "ecmascript"};
  string lower_letters   = "abcdefghijklmnopqrstuvwxyz";
  string keyword_letters = "javscriptemodulkgnr";
  string filler_chars    = "abcdefghijklmnopqrstuvwxyz0123456789-/+";
  logic [7:0] ws_chars[5] = '{STC_CHAR_TAB, STC_CHAR_LF, STC_CHAR_FF, STC_CHAR_CR, STC_CHAR_SPACE};

  // Bytes of the attribute value being built, and class codes still to arrive.
  logic [7:0]  value_bytes[$];
  stc_class_e  expected_classes[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned codes_checked = 0;
  int unsigned bytes_taken = 0;
  int unsigned cycle_count = 0;
  int unsigned class_tally[5] = '{0, 0, 0, 0, 0};

  // Predictor state for the attribute value in progress.
  logic        content_seen     = 1'b0;
  int unsigned trimmed_len      = 0;
  int unsigned trailing_ws      = 0;
  int unsigned js_matched       = 0;
  int unsigned es_matched       = 0;
  logic        script_word_seen = 1'b0;
  int unsigned exact_pos        = 0;
  int unsigned exact_sel        = 0;
  logic        exact_live       = 1'b1;

  script_type_classifier #(
    .MAX_LEN(ATTR_MAX_LEN)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .byte_value_i(byte_value_i),
    .is_last_i   (is_last_i),
    .no_bytes_i  (no_bytes_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .type_class_o(type_class_o)
  );

  // Clock with a period of 10 time units.
  always #5 clk_i = ~clk_i;

  // Cycle counter that ends a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // The result side stalls at random at the current idling rate.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic bit is_ws(logic [7:0] b);
    return b inside {STC_CHAR_TAB, STC_CHAR_LF, STC_CHAR_FF, STC_CHAR_CR, STC_CHAR_SPACE};
  endfunction

  function automatic int unsigned capped(int unsigned v);
    return (v > ATTR_MAX_LEN) ? ATTR_MAX_LEN : v;
  endfunction

  function automatic void clear_value_state();
    content_seen     = 1'b0;
    trimmed_len      = 0;
    trailing_ws      = 0;
    js_matched       = 0;
    es_matched       = 0;
    script_word_seen = 1'b0;
    exact_pos        = 0;
    exact_sel        = 0;
    exact_live       = 1'b1;
  endfunction

  // Advances the search for a script word. Neither word repeats its first letter, so a
  // mismatch falls back to zero or one; a full match is latched and the search restarts.
  function automatic int unsigned script_search(int unsigned pos, string word, logic [7:0] ch);
    int unsigned nxt;
    if (pos < word.len() && word[pos] == ch) nxt = pos + 1;
    else nxt = (word[0] == ch) ? 1 : 0;
    if (nxt == word.len()) begin
      script_word_seen = 1'b1;
      nxt = 0;
    end
    return nxt;
  endfunction

  // Applies one accepted byte to the predictor. Returns 1 when a class code results.
  function automatic bit classify_byte(input logic [7:0] b, input logic last, input logic nob,
                                       output stc_class_e cls);
    logic [7:0] ch;
    string      word;
    cls = STC_CLASS_CLASSIC;
    if (nob) begin
      clear_value_state();
      return 1'b1;
    end
    if (is_ws(b)) begin
      // Whitespace only counts once content has begun; it may still turn out to be trailing.
      if (content_seen) trailing_ws = capped(trailing_ws + 1);
    end else begin
      ch = (b >= STC_CHAR_UPPER_A && b <= STC_CHAR_UPPER_Z) ? b + STC_CASE_OFFSET : b;
      if (!content_seen) begin
        content_seen = 1'b1;
      end else if (trailing_ws != 0) begin
        // Inner whitespace kills the exact match and restarts the substring search.
        exact_live = 1'b0;
        js_matched = 0;
        es_matched = 0;
      end
      trimmed_len = capped(trimmed_len + trailing_ws + 1);
      trailing_ws = 0;
      js_matched  = script_search(js_matched, script_words[0], ch);
      es_matched  = script_search(es_matched, script_words[1], ch);
      // The first character picks the exact keyword; later ones must follow it.
      if (exact_live && exact_pos == 0) begin
        case (ch)
          "m": exact_sel = 0;
          "i": exact_sel = 1;
          "s": exact_sel = 2;
          default: exact_live = 1'b0;
        endcase
      end
      if (exact_live) begin
        word = exact_words[exact_sel];
        if (exact_pos >= word.len() || word[exact_pos] != ch) exact_live = 1'b0;
        else exact_pos++;
      end
    end
    if (!last) return 1'b0;
    word = exact_words[exact_sel];
    if (!content_seen) cls = STC_CLASS_CLASSIC;
    else if (trimmed_len >= ATTR_MAX_LEN) cls = STC_CLASS_NONE;
    else if (script_word_seen) cls = STC_CLASS_CLASSIC;
    else if (exact_live && exact_pos == word.len()) begin
      case (exact_sel)
        0: cls = STC_CLASS_MODULE;
        1: cls = STC_CLASS_IMPORTMAP;
        default: cls = STC_CLASS_SPECRULES;
      endcase
    end else cls = STC_CLASS_NONE;
    clear_value_state();
    return 1'b1;
  endfunction

  // Checks each accepted result against the oldest prediction, then predicts from the
  // byte accepted at the same edge; a result is registered and so always trails its byte.
  always @(posedge clk_i) begin : result_monitor
    stc_class_e predicted;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_classes.size() == 0) begin
          $display("%0t: unexpected class code: expected none pending, actual %0d",
                   $time, type_class_o);
          mismatch_count++;
        end else begin
          predicted = expected_classes.pop_front();
          codes_checked++;
          if (type_class_o !== predicted) begin
            $display("%0t: type_class mismatch: expected %0d (%s), actual %0d",
                     $time, predicted, predicted.name(), type_class_o);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        bytes_taken++;
        if (classify_byte(byte_value_i, is_last_i, no_bytes_i, predicted)) begin
          expected_classes.push_back(predicted);
          class_tally[predicted]++;
        end
      end
    end
  end

  // Sends one transaction, idling at random beforehand, and returns at the edge that takes it.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic nob);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    byte_value_i <= b;
    is_last_i    <= last;
    no_bytes_i   <= nob;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Sends the built value with the last mark on its final byte; an empty value is sent
  // as a single no-bytes transaction.
  task automatic send_value();
    if (value_bytes.size() == 0) begin
      send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    end else begin
      foreach (value_bytes[i]) send_byte(value_bytes[i], i == value_bytes.size() - 1, 1'b0);
    end
  endtask

  // Appends text, turning about one letter in four to upper case.
  function automatic void push_text(string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= "a" && c <= "z" && $urandom_range(3) == 0) c = c - STC_CASE_OFFSET;
      value_bytes.push_back(c);
    end
  endfunction

  function automatic void push_spaces(int unsigned n);
    for (int i = 0; i < n; i++) value_bytes.push_back(ws_chars[$urandom_range(4)]);
  endfunction

  function automatic void push_letters(int unsigned n, string alphabet);
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(alphabet.len() - 1);
      push_text(alphabet.substr(k, k));
    end
  endfunction

  // Special cases one by one: the no-bytes flag, dropped bytes, whitespace only,
  // byte extremes, inner whitespace and a mixed-case script word.
  task automatic test_directed_cases();
    string js_mixed;
    js_mixed = "JaVaScRiPt";
    // The no-bytes flag wins over a last mark.
    send_byte(8'hFF, 1'b1, 1'b1);
    // Bytes without a last mark are dropped by a no-bytes transaction.
    send_byte(STC_CHAR_SPACE, 1'b0, 1'b0);
    send_byte("m", 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    // A value of whitespace alone is classic.
    send_byte(STC_CHAR_TAB, 1'b0, 1'b0);
    send_byte(STC_CHAR_LF, 1'b0, 1'b0);
    send_byte(STC_CHAR_FF, 1'b0, 1'b0);
    send_byte(STC_CHAR_CR, 1'b1, 1'b0);
    // Zero and all-ones bytes match nothing.
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    // Inner whitespace is part of the value.
    send_byte("M", 1'b0, 1'b0);
    send_byte(STC_CHAR_TAB, 1'b0, 1'b0);
    send_byte("o", 1'b1, 1'b0);
    // Script word with upper-case letters folded.
    for (int i = 0; i < js_mixed.len(); i++) send_byte(js_mixed[i], i == js_mixed.len() - 1, 1'b0);
  endtask

  // Exact keywords with padding, mostly intact, some broken in one place.
  task automatic test_exact_keywords(int unsigned count);
    string       word;
    int unsigned cut;
    for (int n = 0; n < count; n++) begin
      value_bytes.delete();
      word = exact_words[$urandom_range(2)];
      cut  = $urandom_range(word.len() - 2);
      push_spaces($urandom_range(3));
      case ($urandom_range(9))
        0: begin
          word[cut] = lower_letters[$urandom_range(25)];
          push_text(word);
        end
        1: push_text(word.substr(0, word.len() - 2));
        2: begin
          push_text(word);
          push_letters(1 + $urandom_range(1), lower_letters);
        end
        3: begin
          push_text(word.substr(0, cut));
          push_spaces(1 + $urandom_range(1));
          push_text(word.substr(cut + 1, word.len() - 1));
        end
        4: begin
          push_letters(1, lower_letters);
          push_text(word);
        end
        default: push_text(word);
      endcase
      push_spaces($urandom_range(3));
      send_value();
    end
  endtask

  // Script words inside other text, with overlaps, gaps and missing letters.
  task automatic test_script_words(int unsigned count);
    string       word;
    int unsigned cut;
    for (int n = 0; n < count; n++) begin
      value_bytes.delete();
      word = script_words[$urandom_range(1)];
      cut  = 1 + $urandom_range(word.len() - 3);
      push_spaces($urandom_range(2));
      push_letters($urandom_range(4), keyword_letters);
      case ($urandom_range(5))
        0: push_text({word.substr(0, cut - 1), word.substr(cut + 1, word.len() - 1)});
        1: begin
          push_text(word.substr(0, cut));
          push_spaces(1);
          push_text(word.substr(cut + 1, word.len() - 1));
        end
        2: begin
          push_text(word.substr(0, cut));
          push_text(word);
        end
        default: push_text(word);
      endcase
      push_letters($urandom_range(4), keyword_letters);
      push_spaces($urandom_range(2));
      send_value();
    end
  endtask

  // Trimmed lengths either side of the limit, and long whitespace runs that saturate.
  task automatic test_length_limit();
    // One below the limit: still classic.
    value_bytes.delete();
    push_text(script_words[0]);
    push_letters(ATTR_MAX_LEN - 1 - script_words[0].len(), filler_chars);
    push_spaces(2);
    send_value();
    // Exactly at the limit: none.
    value_bytes.delete();
    push_text(script_words[1]);
    push_letters(ATTR_MAX_LEN - script_words[1].len(), filler_chars);
    send_value();
    // Long leading and trailing whitespace is not counted.
    value_bytes.delete();
    push_spaces(ATTR_MAX_LEN + 2);
    push_text(exact_words[0]);
    push_spaces(ATTR_MAX_LEN + 2);
    send_value();
    // Inner whitespace counts towards the length.
    value_bytes.delete();
    push_text("a");
    push_spaces(ATTR_MAX_LEN - 2);
    push_text("b");
    send_value();
  endtask

  // Noise: raw bytes, whitespace alone, dropped values, keyword prefixes and loose letters.
  task automatic test_random_values(int unsigned count);
    logic [7:0]  edge_bytes[6];
    string       word;
    int unsigned len;
    edge_bytes = '{8'h40, 8'h5B, 8'h60, 8'h7B, STC_CHAR_UPPER_A, STC_CHAR_UPPER_Z};
    for (int n = 0; n < count; n++) begin
      value_bytes.delete();
      word = exact_words[$urandom_range(2)];
      len  = 1 + $urandom_range(7);
      case ($urandom_range(5))
        0: begin
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(3) == 0) value_bytes.push_back(edge_bytes[$urandom_range(5)]);
            else value_bytes.push_back(8'($urandom_range(255)));
          end
        end
        1: push_spaces($urandom_range(4));
        2: begin
          // Unterminated bytes, then a no-bytes transaction.
          for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
        end
        3: push_text(word.substr(0, $urandom_range(word.len() - 1)));
        4: push_letters(len + $urandom_range(4), {keyword_letters, " "});
        default: begin
          push_text(word);
          value_bytes.push_back(8'($urandom_range(255)));
        end
      endcase
      send_value();
    end
  endtask

  // Reset, the tests under three idling mixes, then drain and report.
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 17;
    recv_idle_pct = 86;
    test_directed_cases();
    test_exact_keywords(30);

    send_idle_pct = 86;
    recv_idle_pct = 17;
    test_script_words(20);
    test_length_limit();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_values(60);
    test_exact_keywords(15);
    test_script_words(10);

    in_valid_i <= 1'b0;
    while (expected_classes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d byte transactions and %0d class codes under three idling mixes.",
             bytes_taken, codes_checked);
    $display("Codes seen: classic %0d, module %0d, importmap %0d, speculationrules %0d, none %0d.",
             class_tally[STC_CLASS_CLASSIC], class_tally[STC_CLASS_MODULE],
             class_tally[STC_CLASS_IMPORTMAP], class_tally[STC_CLASS_SPECRULES],
             class_tally[STC_CLASS_NONE]);
    if (mismatch_count == 0 && expected_classes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
